// ===== rtl/core/plfrp_pkg.sv =====
package plfrp_pkg;

   localparam int unsigned SEED_W = 48;
   localparam int unsigned HALF_W = 24;
   localparam int unsigned TAG_W  = 184;

   // Step multiplier, whole and split into its low 24 and upper 11 bits.
   localparam logic [SEED_W-1:0] LCG_MUL    = 48'h0005_DEEC_E66D;
   localparam logic [HALF_W-1:0] LCG_MUL_LO = 24'hEC_E66D;
   localparam logic [10:0]       LCG_MUL_HI = 11'h5DE;
   localparam logic [SEED_W-1:0] LCG_ADD    = 48'h0000_0000_000B;

   localparam logic [31:0]        HASH_X_MUL  = 32'd3129871;
   localparam logic signed [27:0] HASH_Z_MUL  = 28'sd116129781;
   localparam logic [25:0]        HASH_SQ_MUL = 26'd42317861;

   // Band tags as character codes, first character in the highest byte used.
   localparam logic [TAG_W-1:0] FLOOR_TAG = {
      8'd109, 8'd105, 8'd110, 8'd101, 8'd99, 8'd114, 8'd97, 8'd102, 8'd116, 8'd58,
      8'd98, 8'd101, 8'd100, 8'd114, 8'd111, 8'd99, 8'd107, 8'd95, 8'd102, 8'd108,
      8'd111, 8'd111, 8'd114
   };
   localparam logic [TAG_W-1:0] ROOF_TAG = {
      8'd0,
      8'd109, 8'd105, 8'd110, 8'd101, 8'd99, 8'd114, 8'd97, 8'd102, 8'd116, 8'd58,
      8'd98, 8'd101, 8'd100, 8'd114, 8'd111, 8'd99, 8'd107, 8'd95, 8'd114, 8'd111,
      8'd111, 8'd102
   };

   // Polynomial hash with base 31 over the n characters in the low bytes.
   function automatic logic [31:0] tag_hash(input logic [TAG_W-1:0] t, input int unsigned n);
      logic [31:0] h;
      h = '0;
      for (int unsigned i = 0; i < n; i++) begin
         h = 32'd31 * h + {24'd0, t[8*(n-1-i) +: 8]};
      end
      return h;
   endfunction

   localparam logic [31:0] FLOOR_HASH = tag_hash(FLOOR_TAG, 23);
   localparam logic [31:0] ROOF_HASH  = tag_hash(ROOF_TAG, 22);
   localparam logic [SEED_W-1:0] FLOOR_SALT = {{16{FLOOR_HASH[31]}}, FLOOR_HASH};
   localparam logic [SEED_W-1:0] ROOF_SALT  = {{16{ROOF_HASH[31]}}, ROOF_HASH};

   typedef struct packed {
      logic       is_floor;
      logic       is_roof;
      logic [2:0] y_low;
   } band_type;

   typedef struct packed {
      band_type    band;
      logic [15:0] hi;
   } band_hi_type;

   typedef struct packed {
      band_type          band;
      logic [SEED_W-1:0] hash;
   } band_hash_type;

   typedef struct packed {
      band_type          band;
      logic [SEED_W-1:0] hash;
      logic [15:0]       hi;
   } band_hash_hi_type;

endpackage

// ===== rtl/core/plfrp_lcg_step.sv =====
module plfrp_lcg_step
   import plfrp_pkg::*;
#(
   parameter int unsigned SIDE_W = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [SEED_W-1:0] in_seed,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [SEED_W-1:0] out_seed,
   output logic [SIDE_W-1:0] out_side
);

   logic              p_valid_ff;
   logic              a_valid_ff;
   logic [SEED_W-1:0] p0_ff, p0_in;
   logic [HALF_W-1:0] p1_ff, p1_in;
   logic [HALF_W-1:0] p2_ff, p2_in;
   logic [SIDE_W-1:0] p_side_ff;
   logic [SEED_W-1:0] a_seed_ff, a_seed_in;
   logic [SIDE_W-1:0] a_side_ff;

   // Only the low 48 bits of the product survive, so the upper-by-upper
   // partial product drops out and the cross terms are needed to 24 bits.
   assign p0_in = in_seed[HALF_W-1:0] * LCG_MUL_LO;
   assign p1_in = in_seed[SEED_W-1:HALF_W] * LCG_MUL_LO;
   assign p2_in = in_seed[HALF_W-1:0] * LCG_MUL_HI;

   assign a_seed_in = p0_ff + {p1_ff + p2_ff, {HALF_W{1'b0}}} + LCG_ADD;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         a_valid_ff <= 1'b0;
      end else if (en) begin
         p_valid_ff <= in_valid;
         a_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff     <= p0_in;
         p1_ff     <= p1_in;
         p2_ff     <= p2_in;
         p_side_ff <= in_side;
         a_seed_ff <= a_seed_in;
         a_side_ff <= p_side_ff;
      end
   end

   assign out_valid = a_valid_ff;
   assign out_seed  = a_seed_ff;
   assign out_side  = a_side_ff;

endmodule

// ===== rtl/core/plfrp_pos_hash.sv =====
module plfrp_pos_hash
   import plfrp_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [31:0]       pos_x,
   input  logic [31:0]       pos_y,
   input  logic [31:0]       pos_z,
   output logic [SEED_W-1:0] hash
);

   logic [31:0]        a_ff, a_in;
   logic signed [59:0] zp;
   logic [63:0]        b_ff, b_in;
   logic [31:0]        y_ff;
   logic [63:0]        l_ff, l_in;
   logic [63:0]        sq_lo_ff, sq_lo_in;
   logic [31:0]        cross_ff, cross_in;
   logic [63:0]        sq_ff, sq_in;
   logic [63:0]        l11_ff, l11_in;
   logic [57:0]        plo_ff, plo_in;
   logic [31:0]        phi_ff, phi_in;
   logic [63:0]        l11b_ff;
   logic [63:0]        lf;
   logic [SEED_W-1:0]  hash_ff;

   assign a_in = pos_x * HASH_X_MUL;
   assign zp   = $signed(pos_z) * HASH_Z_MUL;
   assign b_in = {{4{zp[59]}}, zp};

   assign l_in     = {{32{a_ff[31]}}, a_ff} ^ b_ff ^ {{32{y_ff[31]}}, y_ff};
   // Square modulo 2^64 from the low half squared and one cross term.
   assign sq_lo_in = l_in[31:0] * l_in[31:0];
   assign cross_in = l_in[63:32] * l_in[31:0];

   assign sq_in  = sq_lo_ff + {cross_ff[30:0], 33'd0};
   assign l11_in = (l_ff << 3) + (l_ff << 1) + l_ff;

   assign plo_in = sq_ff[31:0] * HASH_SQ_MUL;
   assign phi_in = sq_ff[63:32] * HASH_SQ_MUL;

   assign lf = {6'd0, plo_ff} + {phi_ff, 32'd0} + l11b_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff     <= a_in;
         b_ff     <= b_in;
         y_ff     <= pos_y;
         l_ff     <= l_in;
         sq_lo_ff <= sq_lo_in;
         cross_ff <= cross_in;
         sq_ff    <= sq_in;
         l11_ff   <= l11_in;
         plo_ff   <= plo_in;
         phi_ff   <= phi_in;
         l11b_ff  <= l11_ff;
         hash_ff  <= lf[63:16];
      end
   end

   assign hash = hash_ff;

endmodule

// ===== rtl/core/positional_lcg_floor_roof_predicate.sv =====
// Solidity predicate for a floor band and a roof band of a 3-D grid.
// Input channel req_*: one signed coordinate (x, y, z) per item. Result channel
// rsp_*: one item per input item, in order, carrying is_solid.
// Configuration: csr_write_en with csr_write_data loads the 48-bit world seed.
// It is to be written only while no item is in flight.
// Pipeline: the input register, then five 48-bit generator steps, each split
// into a partial-product stage and a sum stage, then the output register; the
// position hash runs alongside in its own five stages.
// Throughput: one item per cycle, sustained for as long as results are taken.
// Reset clears every valid bit and the world seed; no result is pending after it.
// Stall: the output register is backed by one skid entry. When a result cannot
// be handed over, the next one goes into the skid entry and req_tready falls in
// the following cycle; the whole pipeline then holds until the skid entry drains.
// Nothing is dropped or repeated across a stall.
module positional_lcg_floor_roof_predicate
   import plfrp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_en,
   input  logic [SEED_W-1:0] csr_write_data,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [95:0]       req_tdata,   // pos_x [31:0], pos_y [63:32], pos_z [95:64]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata    // is_solid [0], zero above
);

   localparam int unsigned BAND_W     = $bits(band_type);
   localparam int unsigned BAND_HI_W  = $bits(band_hi_type);
   localparam int unsigned BAND_HA_W  = $bits(band_hash_type);
   localparam int unsigned BAND_HH_W  = $bits(band_hash_hi_type);

   logic [SEED_W-1:0] world_seed_ff;
   logic              en;

   logic [31:0] pos_x, pos_y, pos_z;

   logic              s1_valid_ff;
   logic [SEED_W-1:0] s1_seed_ff;
   band_type          s1_band_ff, s1_band_in;

   logic              l1_valid;
   logic [SEED_W-1:0] l1_seed;
   band_type          l1_band;
   band_hi_type       l2_side_in, l2_side;
   logic              l2_valid;
   logic [SEED_W-1:0] l2_seed;
   logic [SEED_W-1:0] hash;
   logic [15:0]       t1_hi;
   logic [SEED_W-1:0] l3_seed_in;
   band_hash_type     l3_side_in, l3_side;
   logic              l3_valid;
   logic [SEED_W-1:0] l3_seed;
   band_hash_hi_type  l4_side_in, l4_side;
   logic              l4_valid;
   logic [SEED_W-1:0] l4_seed;
   logic [15:0]       t2_hi;
   logic [SEED_W-1:0] l5_seed_in;
   band_type          l5_side;
   logic              l5_valid;
   logic [SEED_W-1:0] l5_seed;

   logic [26:0] r24_x5;
   logic [26:0] limit;
   logic [2:0]  limit_k;
   logic        solid_in;

   logic out_valid_ff;
   logic out_solid_ff;
   logic skid_valid_ff;
   logic skid_solid_ff;
   logic out_free;

   assign pos_x = req_tdata[31:0];
   assign pos_y = req_tdata[63:32];
   assign pos_z = req_tdata[95:64];

   // The pipeline moves as one while the skid entry is empty.
   assign en         = !skid_valid_ff;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         world_seed_ff <= '0;
      end else if (csr_write_en) begin
         world_seed_ff <= csr_write_data;
      end
   end

   assign s1_band_in.is_floor = (pos_y <= 32'd4);
   assign s1_band_in.is_roof  = (pos_y >= 32'd123) && (pos_y <= 32'd127);
   assign s1_band_in.y_low    = pos_y[2:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_seed_ff <= world_seed_ff ^ LCG_MUL;
         s1_band_ff <= s1_band_in;
      end
   end

   plfrp_pos_hash u_pos_hash (
      .clock (clock),
      .en    (en),
      .pos_x (pos_x),
      .pos_y (pos_y),
      .pos_z (pos_z),
      .hash  (hash)
   );

   plfrp_lcg_step #(.SIDE_W(BAND_W)) u_step1 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s1_valid_ff),
      .in_seed   (s1_seed_ff),
      .in_side   (s1_band_ff),
      .out_valid (l1_valid),
      .out_seed  (l1_seed),
      .out_side  (l1_band)
   );

   assign l2_side_in.band = l1_band;
   assign l2_side_in.hi   = l1_seed[31:16];

   plfrp_lcg_step #(.SIDE_W(BAND_HI_W)) u_step2 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (l1_valid),
      .in_seed   (l1_seed),
      .in_side   (l2_side_in),
      .out_valid (l2_valid),
      .out_seed  (l2_seed),
      .out_side  (l2_side)
   );

   // First draw kept to 48 bits: the sign-extended low word borrows one from
   // the low sixteen bits of the high word when it is negative.
   assign t1_hi      = l2_side.hi - {15'd0, l2_seed[47]};
   assign l3_seed_in = {t1_hi, l2_seed[47:16]} ^ LCG_MUL ^
                       (l2_side.band.is_floor ? FLOOR_SALT : ROOF_SALT);
   assign l3_side_in.band = l2_side.band;
   assign l3_side_in.hash = hash;

   plfrp_lcg_step #(.SIDE_W(BAND_HA_W)) u_step3 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (l2_valid),
      .in_seed   (l3_seed_in),
      .in_side   (l3_side_in),
      .out_valid (l3_valid),
      .out_seed  (l3_seed),
      .out_side  (l3_side)
   );

   assign l4_side_in.band = l3_side.band;
   assign l4_side_in.hash = l3_side.hash;
   assign l4_side_in.hi   = l3_seed[31:16];

   plfrp_lcg_step #(.SIDE_W(BAND_HH_W)) u_step4 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (l3_valid),
      .in_seed   (l3_seed),
      .in_side   (l4_side_in),
      .out_valid (l4_valid),
      .out_seed  (l4_seed),
      .out_side  (l4_side)
   );

   assign t2_hi      = l4_side.hi - {15'd0, l4_seed[47]};
   assign l5_seed_in = {t2_hi, l4_seed[47:16]} ^ l4_side.hash ^ LCG_MUL;

   plfrp_lcg_step #(.SIDE_W(BAND_W)) u_step5 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (l4_valid),
      .in_seed   (l5_seed_in),
      .in_side   (l4_side.band),
      .out_valid (l5_valid),
      .out_seed  (l5_seed),
      .out_side  (l5_side)
   );

   // Threshold compare on the top 24 bits; the roof distance 127 - y equals
   // 7 minus the low three bits of y within the band.
   assign r24_x5  = {3'd0, l5_seed[47:24]} + {1'b0, l5_seed[47:24], 2'd0};
   assign limit_k = l5_side.is_floor ? (3'd5 - l5_side.y_low) : (3'd7 - l5_side.y_low);
   assign limit   = {limit_k, 24'd0};

   always_comb begin
      priority if (l5_side.is_floor) begin
         solid_in = (r24_x5 < limit);
      end else if (l5_side.is_roof) begin
         solid_in = (r24_x5 > limit);
      end else begin
         solid_in = 1'b0;
      end
   end

   assign out_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (en) begin
         if (out_free) begin
            out_valid_ff <= l5_valid;
         end else if (l5_valid) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_tready) begin
         skid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (out_free) begin
            out_solid_ff <= solid_in;
         end else begin
            skid_solid_ff <= solid_in;
         end
      end else if (rsp_tready) begin
         out_solid_ff <= skid_solid_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_solid_ff};

   a_skid_needs_output : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds an item while the output register is empty");

   a_overflow_to_skid : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready && l5_valid && !skid_valid_ff |=> skid_valid_ff)
      else $error("result leaving the pipeline during a stall was not kept");

   a_skid_drains : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && rsp_tready |=> out_valid_ff && !skid_valid_ff)
      else $error("skid entry did not move to the output register");

   a_bands_exclusive : assert property (@(posedge clock) disable iff (reset)
      l5_valid |-> !(l5_side.is_floor && l5_side.is_roof))
      else $error("item marked as both floor and roof");

   a_outside_band_empty : assert property (@(posedge clock) disable iff (reset)
      l5_valid && !l5_side.is_floor && !l5_side.is_roof |-> !solid_in)
      else $error("cell outside both bands reported solid");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam logic [63:0] STEP_MUL   = 64'h0000_0005_DEEC_E66D;
   localparam logic [63:0] STEP_ADD   = 64'h0000_0000_0000_000B;
   localparam logic [63:0] MASK48     = 64'h0000_FFFF_FFFF_FFFF;
   localparam logic [31:0] X_HASH_MUL = 32'd3129871;
   localparam logic [63:0] Z_HASH_MUL = 64'd116129781;
   localparam logic [63:0] SQ_MUL     = 64'd42317861;

   // Band tag character codes, first character in the lowest byte.
   localparam logic [8*23-1:0] FLOOR_CODES = {
      8'd114, 8'd111, 8'd111, 8'd108, 8'd102, 8'd95, 8'd107, 8'd99, 8'd111, 8'd114,
      8'd100, 8'd101, 8'd98, 8'd58, 8'd116, 8'd102, 8'd97, 8'd114, 8'd99, 8'd101,
      8'd110, 8'd105, 8'd109
   };
   localparam logic [8*23-1:0] ROOF_CODES = {
      8'd0,
      8'd102, 8'd111, 8'd111, 8'd114, 8'd95, 8'd107, 8'd99, 8'd111, 8'd114, 8'd100,
      8'd101, 8'd98, 8'd58, 8'd116, 8'd102, 8'd97, 8'd114, 8'd99, 8'd101, 8'd110,
      8'd105, 8'd109
   };

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_write_en = 1'b0;
   logic [plfrp_pkg::SEED_W-1:0] csr_write_data = '0;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [95:0]                 req_tdata = '0;   // pos_x [31:0], pos_y [63:32], pos_z [95:64]
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [7:0]                  rsp_tdata;        // is_solid [0], zero above

   logic [95:0] coord_queue[$];
   logic [7:0]  solid_expect[$];
   logic [47:0] seed_copy = '0;
   logic [7:0]  want;
   int          items_queued = 0;
   int          items_accepted = 0;
   int          mismatch_count = 0;
   int          send_gap = 0;
   int          hold_left = 0;
   logic        long_hold_done = 1'b0;
   logic        calm = 1'b0;

   positional_lcg_floor_roof_predicate i_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] poly31(input logic [8*23-1:0] codes, input int n);
      logic [31:0] h;
      h = '0;
      for (int i = 0; i < n; i++) begin
         h = h * 32'd31 + {24'd0, codes[8*i +: 8]};
      end
      return h;
   endfunction

   function automatic logic [63:0] sext64(input logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   function automatic logic [63:0] next_state(input logic [63:0] s);
      return (s * STEP_MUL + STEP_ADD) & MASK48;
   endfunction

   // Two steps: the first gives the upper word, the second a sign-extended lower word.
   function automatic logic [63:0] draw_from(input logic [63:0] s);
      logic [63:0] s1, s2;
      s1 = next_state(s);
      s2 = next_state(s1);
      return {s1[47:16], 32'd0} + sext64(s2[47:16]);
   endfunction

   function automatic logic predict_solid(input logic [47:0] seed,
                                          input logic [31:0] x, y, z);
      logic [63:0] s, t, salt, l, r24;
      logic [31:0] lane;
      logic        in_floor, in_roof;
      in_floor = !y[31] && y <= 32'd4;
      in_roof  = !y[31] && y >= 32'd123 && y <= 32'd127;
      if (!in_floor && !in_roof) begin
         return 1'b0;
      end
      salt = in_floor ? sext64(poly31(FLOOR_CODES, 23)) : sext64(poly31(ROOF_CODES, 22));
      t = draw_from(({16'd0, seed} ^ STEP_MUL) & MASK48) & MASK48;
      t = draw_from((t ^ salt ^ STEP_MUL) & MASK48) & MASK48;
      lane = x * X_HASH_MUL;
      l = sext64(lane) ^ (sext64(z) * Z_HASH_MUL) ^ sext64(y);
      l = l * l * SQ_MUL + l * 64'd11;
      t = t ^ (l >> 16);
      s = next_state((t ^ STEP_MUL) & MASK48);
      r24 = s >> 24;
      if (in_floor) begin
         return (r24 * 64'd5) < ((64'd5 - {32'd0, y}) << 24);
      end
      return (r24 * 64'd5) > ((64'd127 - {32'd0, y}) << 24);
   endfunction

   function automatic logic [31:0] pick_axis();
      case ($urandom_range(0, 3))
         0: begin
            return $urandom_range(0, 2000) - 1000;
         end
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   // Most items land in one of the two bands, where the full hash chain is exercised.
   function automatic logic [31:0] pick_y();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 7) begin
         return $urandom_range(0, 4);
      end else if (pick < 14) begin
         return $urandom_range(123, 127);
      end else if (pick < 17) begin
         return $urandom_range(0, 140) - 5;
      end
      return $urandom;
   endfunction

   task automatic push_coord(input logic [31:0] x, y, z);
      coord_queue.push_back({z, y, x});
      items_queued++;
   endtask

   task automatic add_random_items(input int n);
      repeat (n) begin
         push_coord(pick_axis(), pick_y(), pick_axis());
      end
   endtask

   task automatic wait_drained();
      while (items_accepted != items_queued || solid_expect.size() != 0) begin
         @(posedge clock);
      end
      repeat (16) @(posedge clock);
   endtask

   task automatic load_seed(input logic [47:0] value);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // Sender: takes the next pending item once the current one has gone, with random gaps outside the calm phase.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap != 0) begin
            send_gap = send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 18) - 1;
            req_tvalid <= 1'b0;
         end else if (coord_queue.size() != 0) begin
            req_tdata  <= coord_queue.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: short random stalls, and once a long one so that the block backs up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!long_hold_done && items_accepted >= 300) begin
         long_hold_done = 1'b1;
         hold_left = 299;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         hold_left = $urandom_range(1, 18) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_en) begin
            seed_copy = csr_write_data;
         end
         if (req_tvalid && req_tready) begin
            solid_expect.push_back({7'd0, predict_solid(seed_copy, req_tdata[31:0],
                                                        req_tdata[63:32], req_tdata[95:64])});
            items_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (solid_expect.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("result item with nothing expected: rsp_tdata %h", rsp_tdata);
               end
               mismatch_count++;
            end else begin
               want = solid_expect.pop_front();
               if (rsp_tdata !== want) begin
                  if (mismatch_count < 10) begin
                     $display("is_solid mismatch: expected %h, got %h", want, rsp_tdata);
                  end
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Both bands at every y, the band edges, and the extremes of x and z.
      push_coord(32'h0000_0000, 32'd0, 32'h0000_0000);
      push_coord(32'h7FFF_FFFF, 32'd1, 32'h8000_0000);
      push_coord(32'h8000_0000, 32'd2, 32'h7FFF_FFFF);
      push_coord(32'hFFFF_FFFF, 32'd3, 32'hFFFF_FFFF);
      push_coord(32'h0000_0001, 32'd4, 32'h0000_0001);
      push_coord(32'h8000_0000, 32'd123, 32'h8000_0000);
      push_coord(32'h7FFF_FFFF, 32'd124, 32'h7FFF_FFFF);
      push_coord(32'h0000_0000, 32'd125, 32'hFFFF_FFFF);
      push_coord(32'hFFFF_FFFF, 32'd126, 32'h0000_0000);
      push_coord(32'h1234_5678, 32'd127, 32'h9ABC_DEF0);
      push_coord(32'h0000_0000, 32'd5, 32'h0000_0000);
      push_coord(32'h0000_0000, 32'd122, 32'h0000_0000);
      push_coord(32'h0000_0000, 32'd128, 32'h0000_0000);
      push_coord(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
      push_coord(32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      push_coord(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      push_coord(32'h0000_0000, 32'h0000_007B | 32'h8000_0000, 32'h0000_0000);
      push_coord(32'h0000_0000, 32'h0000_0100, 32'h0000_0000);
      push_coord(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
      push_coord(32'h8000_0000, 32'd127, 32'h0000_0000);
      add_random_items(100);
      wait_drained();

      load_seed(48'hFFFF_FFFF_FFFF);
      add_random_items(300);
      wait_drained();

      load_seed(48'd0);
      add_random_items(150);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         load_seed({$urandom, $urandom});
         if (phase == 3) begin
            calm = 1'b1;
         end
         add_random_items(170);
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && solid_expect.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
